[design/pflrq_pkg.sv]
package pflrq_pkg;

  localparam int unsigned NumSlotsDef  = 16;
  localparam int unsigned NumLevelsDef = 16;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned FIELD_W      = 4;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ENQUEUE = 2'd2,
    OP_DEQUEUE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ENQ_LINK,
    ST_DEQ_POP
  } state_e;

  typedef struct packed {
    logic load;
    logic alloc;
    logic release_slot;
    logic enq_first;
    logic enq_link;
    logic deq_read;
    logic deq_pop;
    logic emit_hit;
    logic emit_miss;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic slot_ok;
    logic level_ok;
    logic free_empty;
    logic head_none;
    logic tail_none;
    logic out_free;
  } dp_sts_t;

endpackage

[design/pflrq_ram.sv]
module pflrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pflrq_ctrl.sv]
module pflrq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pflrq_pkg::dp_sts_t sts_i,
  output pflrq_pkg::dp_cmd_t cmd_o
);
  import pflrq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
          unique case (sts_i.op)
            OP_ENQUEUE: begin
              if (sts_i.slot_ok && sts_i.level_ok && !sts_i.head_none && !sts_i.tail_none)
                state_d = ST_ENQ_LINK;
            end
            OP_DEQUEUE: begin
              if (sts_i.level_ok && !sts_i.head_none) state_d = ST_DEQ_POP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ENQ_LINK, ST_DEQ_POP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          unique case (sts_i.op)
            OP_ALLOC: begin
              if (sts_i.free_empty) begin
                cmd_o.emit_miss = 1'b1;
              end else begin
                cmd_o.alloc    = 1'b1;
                cmd_o.emit_hit = 1'b1;
              end
            end
            OP_RELEASE: begin
              if (!sts_i.slot_ok) begin
                cmd_o.emit_miss = 1'b1;
              end else begin
                cmd_o.release_slot = 1'b1;
                cmd_o.emit_hit     = 1'b1;
              end
            end
            OP_ENQUEUE: begin
              if (!(sts_i.slot_ok && sts_i.level_ok)) begin
                cmd_o.emit_miss = 1'b1;
              end else begin
                cmd_o.enq_first = 1'b1;
                cmd_o.emit_hit  = sts_i.head_none || sts_i.tail_none;
              end
            end
            OP_DEQUEUE: begin
              if (!sts_i.level_ok || sts_i.head_none) begin
                cmd_o.emit_miss = 1'b1;
              end else begin
                cmd_o.deq_read = 1'b1;
              end
            end
            default: cmd_o.emit_miss = 1'b1;
          endcase
        end
      end
      ST_ENQ_LINK: begin
        if (sts_i.out_free) begin
          cmd_o.enq_link = 1'b1;
          cmd_o.emit_hit = 1'b1;
        end
      end
      ST_DEQ_POP: begin
        if (sts_i.out_free) begin
          cmd_o.deq_pop  = 1'b1;
          cmd_o.emit_hit = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/pflrq_dp.sv]
module pflrq_dp #(
  parameter int unsigned NUM_SLOTS  = pflrq_pkg::NumSlotsDef,
  parameter int unsigned NUM_LEVELS = pflrq_pkg::NumLevelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pflrq_pkg::OP_W-1:0]    operation_i,
  input  logic [pflrq_pkg::FIELD_W-1:0] slot_i,
  input  logic [pflrq_pkg::FIELD_W-1:0] level_i,
  input  pflrq_pkg::dp_cmd_t            cmd_i,
  output pflrq_pkg::dp_sts_t            sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pflrq_pkg::FIELD_W-1:0] result_slot_o,
  output logic                          found_o
);
  import pflrq_pkg::*;

  localparam int unsigned LW   = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SAW  = $clog2(NUM_SLOTS);
  localparam int unsigned LAW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned HQW  = 2 * LW;
  localparam logic [LW-1:0] NONE = LW'(NUM_SLOTS);

  op_e                  op_q;
  logic [FIELD_W-1:0]   slot_q, level_q;
  logic [LW-1:0]        free_head_q, free_head_d;
  logic [LW-1:0]        head_q, tail_q;
  logic [NUM_SLOTS-1:0] link_vld_q;
  logic [NUM_LEVELS-1:0] hq_vld_q;
  logic [SAW-1:0]       link_raddr_q;
  logic [LAW-1:0]       hq_raddr_q;
  logic                 out_valid_q;
  logic [FIELD_W-1:0]   result_slot_q;
  logic                 found_q;

  logic                 link_we, link_re;
  logic [SAW-1:0]       link_waddr, link_raddr;
  logic [LW-1:0]        link_wdata, link_rdata, link_eff;
  logic                 hq_we, hq_re;
  logic [LAW-1:0]       hq_waddr, hq_raddr;
  logic [HQW-1:0]       hq_wdata, hq_rdata, hq_eff;
  logic [LW-1:0]        hq_head, hq_tail;
  logic                 head_none, tail_none;
  logic [FIELD_W-1:0]   hit_slot;

  pflrq_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS), .AW(SAW)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  pflrq_ram #(.WIDTH(HQW), .DEPTH(NUM_LEVELS), .AW(LAW)) u_hq_ram (
    .clk_i   (clk_i),
    .we_i    (hq_we),
    .waddr_i (hq_waddr),
    .wdata_i (hq_wdata),
    .re_i    (hq_re),
    .raddr_i (hq_raddr),
    .rdata_o (hq_rdata)
  );

  // never-written entries read as their reset contents
  assign link_eff = link_vld_q[link_raddr_q] ? link_rdata
                                             : LW'(link_raddr_q) + LW'(1);
  assign hq_eff   = hq_vld_q[hq_raddr_q] ? hq_rdata : {NONE, NONE};
  assign hq_head  = hq_eff[HQW-1:LW];
  assign hq_tail  = hq_eff[LW-1:0];
  assign head_none = hq_head >= NONE;
  assign tail_none = hq_tail >= NONE;

  // link memory port
  always_comb begin
    link_re    = cmd_i.load || cmd_i.deq_read;
    link_raddr = cmd_i.load ? SAW'(free_head_q) : SAW'(hq_head);
    link_we    = cmd_i.release_slot || cmd_i.enq_first || cmd_i.enq_link;
    link_waddr = cmd_i.enq_link ? SAW'(tail_q) : SAW'(slot_q);
    link_wdata = NONE;
    if (cmd_i.release_slot) begin
      link_wdata = free_head_q;
    end else if (cmd_i.enq_link) begin
      link_wdata = LW'(slot_q);
    end
  end

  // head and tail memory port
  always_comb begin
    hq_re    = cmd_i.load;
    hq_raddr = LAW'(level_i);
    hq_we    = cmd_i.enq_first || cmd_i.deq_pop;
    hq_waddr = LAW'(level_q);
    if (cmd_i.deq_pop) begin
      hq_wdata = {link_eff, (link_eff >= NONE) ? NONE : tail_q};
    end else begin
      hq_wdata = {(head_none || tail_none) ? LW'(slot_q) : hq_head, LW'(slot_q)};
    end
  end

  always_comb begin
    free_head_d = free_head_q;
    if (cmd_i.alloc) begin
      free_head_d = link_eff;
    end else if (cmd_i.release_slot) begin
      free_head_d = LW'(slot_q);
    end
  end

  always_comb begin
    unique case (op_q)
      OP_ALLOC:   hit_slot = FIELD_W'(free_head_q);
      OP_DEQUEUE: hit_slot = FIELD_W'(head_q);
      default:    hit_slot = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      link_vld_q  <= '0;
      hq_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      if (link_we) link_vld_q[link_waddr] <= 1'b1;
      if (hq_we) hq_vld_q[hq_waddr] <= 1'b1;
      if (cmd_i.emit_hit || cmd_i.emit_miss) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(operation_i);
      slot_q  <= slot_i;
      level_q <= level_i;
    end
    if (link_re) link_raddr_q <= link_raddr;
    if (hq_re) hq_raddr_q <= hq_raddr;
    if (cmd_i.enq_first || cmd_i.deq_read) begin
      head_q <= hq_head;
      tail_q <= hq_tail;
    end
    if (cmd_i.emit_hit) begin
      result_slot_q <= hit_slot;
      found_q       <= 1'b1;
    end else if (cmd_i.emit_miss) begin
      result_slot_q <= '0;
      found_q       <= 1'b0;
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.slot_ok    = 32'(slot_q) < NUM_SLOTS;
    sts_o.level_ok   = 32'(level_q) < NUM_LEVELS;
    sts_o.free_empty = free_head_q >= NONE;
    sts_o.head_none  = head_none;
    sts_o.tail_none  = tail_none;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign result_slot_o = result_slot_q;
  assign found_o       = found_q;

endmodule

[design/process_free_list_and_ready_queues_unit.sv]
// channel   dir   handshake                      payload
// s_axis    in    s_axis_tvalid / s_axis_tready  tdata: operation, slot, level
// m_axis    out   m_axis_tvalid / m_axis_tready  tdata: result_slot, found
//
// one word at a time: allocate, release, enqueue onto an empty level and misses
// run ST_IDLE, ST_EXEC; enqueue onto a busy level and a dequeue hit add ST_ENQ_LINK
// or ST_DEQ_POP, set by the shared link memory's one write port and registered read
// reset: free list holds every slot in order, all levels empty, no clearing pass
// a held result stalls the next word in ST_EXEC until m_axis_tready
module process_free_list_and_ready_queues_unit #(
  parameter int unsigned NUM_SLOTS  = pflrq_pkg::NumSlotsDef,
  parameter int unsigned NUM_LEVELS = pflrq_pkg::NumLevelsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pflrq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // operation, slot, level
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pflrq_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // result_slot, found
);
  import pflrq_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [FIELD_W-1:0] result_slot;
  logic               found;

  pflrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pflrq_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (s_axis_tdata[OP_W-1:0]),
    .slot_i        (s_axis_tdata[OP_W+FIELD_W-1:OP_W]),
    .level_i       (s_axis_tdata[OP_W+2*FIELD_W-1:OP_W+FIELD_W]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_slot_o (result_slot),
    .found_o       (found)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - FIELD_W - 1){1'b0}}, found, result_slot};

endmodule
